>>> hw/rtl/kwm_pkg.sv
// Shared types and constants for the k-way merge selector.
// Used by kwm_ctrl, kwm_dp and kway_merge_by_source_address_top; no dependencies.
package kwm_pkg;

    localparam int LANES  = 16;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    // Width of the lane field on the ports.
    localparam int PORT_LANE_W = 4;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_PICK  = 2'd2;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_V4   = 2'd1;
    localparam logic [1:0] CLASS_V6   = 2'd2;

    // Class sits on top so that a plain unsigned compare orders the keys.
    typedef struct packed {
        logic [1:0]  cls;
        logic [63:0] upper;
        logic [63:0] lower;
    } t_key;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic load;
        logic close;
        logic clear;
        logic read;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

>>> hw/rtl/kwm_dp.sv
// Datapath of the k-way merge selector: head key memory, open flags and the
// scan comparator. Depends on kwm_pkg; driven by kwm_ctrl.
module kwm_dp
    import kwm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [PORT_LANE_W-1:0] i_lane,
    input  logic [1:0]             i_addr_class,
    input  logic [63:0]            i_addr_hi,
    input  logic [63:0]            i_addr_lo,
    output t_dp_sts                o_sts,
    output logic [PORT_LANE_W-1:0] o_winner_lane,
    output logic                   o_none_open
);

    t_key              r_mem [LANES];
    logic [LANES-1:0]  r_key_vld;
    logic [LANES-1:0]  r_open;

    logic [LANE_W-1:0] r_idx;
    logic              r_rd_ok;
    t_key              r_rd_key;
    logic              r_rd_vld;
    logic              r_rd_open;
    logic [LANE_W-1:0] r_rd_lane;

    t_key              r_best;
    logic [LANE_W-1:0] r_best_lane;
    logic              r_found;

    logic [LANE_W-1:0] wr_idx;
    logic              lane_ok;
    logic              key_wr;
    t_key              wr_key;
    t_key              cand;
    logic              take;

    assign wr_idx  = LANE_W'(i_lane);
    assign lane_ok = (32'(i_lane) < LANES);
    assign key_wr  = i_cmd.load && lane_ok
                     && (i_addr_class == CLASS_V4 || i_addr_class == CLASS_V6);

    always_comb begin
        wr_key.cls = i_addr_class;
        if (i_addr_class == CLASS_V4) begin
            wr_key.upper = '0;
            wr_key.lower = {32'd0, i_addr_lo[31:0]};
        end else begin
            wr_key.upper = i_addr_hi;
            wr_key.lower = i_addr_lo;
        end
    end

    // A head never written reads as the all-zero reset key.
    assign cand = r_rd_vld ? r_rd_key : '0;
    assign take = r_rd_ok && r_rd_open && (!r_found || (cand < r_best));

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_mem[wr_idx] <= wr_key;
        end
        if (i_cmd.read) begin
            r_rd_key <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_vld  <= r_key_vld[r_idx];
            r_rd_open <= r_open[r_idx];
            r_rd_lane <= r_idx;
        end
        if (take) begin
            r_best      <= cand;
            r_best_lane <= r_rd_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
            r_open    <= '0;
            r_idx     <= '0;
            r_rd_ok   <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            if (key_wr) begin
                r_key_vld[wr_idx] <= 1'b1;
            end
            if (i_cmd.load && lane_ok) begin
                r_open[wr_idx] <= 1'b1;
            end
            if (i_cmd.close && lane_ok) begin
                r_open[wr_idx] <= 1'b0;
            end
            r_rd_ok <= i_cmd.read;
            if (i_cmd.clear) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.read) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    assign o_sts.last    = (r_idx == LANE_W'(LANES - 1));
    assign o_winner_lane = r_found ? PORT_LANE_W'(r_best_lane) : '0;
    assign o_none_open   = !r_found;

endmodule

>>> hw/rtl/kwm_ctrl.sv
// Controller of the k-way merge selector: decodes commands and sequences the
// lane scan of a pick. Depends on kwm_pkg; drives kwm_dp.
module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_kind,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       busy,
    output logic       o_valid
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_kind == KIND_PICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_REPORT;
            ST_REPORT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy        = 1'b0;
                o_cmd.load  = accept && (i_kind == KIND_LOAD);
                o_cmd.close = accept && (i_kind == KIND_CLOSE);
                o_cmd.clear = accept && (i_kind == KIND_PICK);
            end
            ST_SCAN: begin
                o_cmd.read = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.read = 1'b0;
            end
            ST_REPORT: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A pick that is taken keeps the block busy on the next cycle.
    a_pick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_PICK) |=> busy)
        else $error("pick accepted without entering the scan");

    // The result strobe lasts one cycle and the block is free right after.
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe held or block stuck");

    // Loads and closes never start a scan.
    a_no_scan_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_LOAD || i_kind == KIND_CLOSE)) |=> !busy)
        else $error("load or close took more than one cycle");

    // Memory reads happen only while busy.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |-> busy)
        else $error("head read outside a scan");

endmodule

>>> hw/rtl/kway_merge_by_source_address_top.sv
// Top level of the k-way merge selector by source address.
// Depends on kwm_pkg, kwm_ctrl and kwm_dp.
//
//  Channel   Handshake                 Beat contents
//  --------  ------------------------  ------------------------------------------
//  command   start, busy (taken when   i_kind, i_lane, i_addr_class,
//            start is high, busy low)  i_addr_hi, i_addr_lo
//  result    o_valid (one-cycle pulse) o_winner_lane, o_none_open
//
// A load or close beat is done in the accepting cycle; busy stays low and the
// next beat may follow at once. A pick beat scans the sixteen lane heads with
// a single comparator, one lane per cycle out of the head memory: the scan
// state reads every head in turn, the drain state compares the last head and
// the report state raises the strobe, and the block is free again on the
// cycle after the strobe.
// Reset is synchronous and active low; it closes every lane and marks every
// head key as zero through per-lane valid bits, so no clearing pass is needed.
// The receiver cannot stall: each result is flagged by o_valid for exactly one cycle.
module kway_merge_by_source_address_top
    import kwm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_kind,
    input  logic [PORT_LANE_W-1:0] i_lane,
    input  logic [1:0]             i_addr_class,
    input  logic [63:0]            i_addr_hi,
    input  logic [63:0]            i_addr_lo,
    output logic                   o_valid,
    output logic [PORT_LANE_W-1:0] o_winner_lane,
    output logic                   o_none_open
);

    // Command and status between the sequencer and the datapath.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller decodes each accepted beat and walks the scan of a pick.
    kwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // The datapath holds the lane heads and keeps the running minimum; its
    // winner outputs stay stable through the result cycle.
    kwm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_lane        (i_lane),
        .i_addr_class  (i_addr_class),
        .i_addr_hi     (i_addr_hi),
        .i_addr_lo     (i_addr_lo),
        .o_sts         (sts),
        .o_winner_lane (o_winner_lane),
        .o_none_open   (o_none_open)
    );

endmodule

>>> bench/kway_merge_by_source_address_top_tb.sv
// Self-checking testbench for kway_merge_by_source_address_top.
// Holds a scoreboard class that predicts each pick winner, plus the top bench module.
// Depends on kwm_pkg and the RTL of the merge selector only.

typedef struct packed {
    logic [kwm_pkg::PORT_LANE_W-1:0] lane;
    logic                            none_open;
} winner_t;

class winner_scoreboard;
    logic [1:0]  head_cls   [kwm_pkg::LANES];
    logic [63:0] head_upper [kwm_pkg::LANES];
    logic [63:0] head_lower [kwm_pkg::LANES];
    bit          lane_live  [kwm_pkg::LANES];
    winner_t     expected_winners[$];
    int          mismatches;
    int          results_seen;

    function new();
        for (int i = 0; i < kwm_pkg::LANES; i++) begin
            head_cls[i]   = kwm_pkg::CLASS_NONE;
            head_upper[i] = '0;
            head_lower[i] = '0;
            lane_live[i]  = 1'b0;
        end
        mismatches   = 0;
        results_seen = 0;
    endfunction

    // Class first, then the address as one big-endian number.
    function bit key_below(int a, int b);
        if (head_cls[a] != head_cls[b])
            return head_cls[a] < head_cls[b];
        if (head_cls[a] == kwm_pkg::CLASS_NONE)
            return 1'b0;
        if (head_upper[a] != head_upper[b])
            return head_upper[a] < head_upper[b];
        return head_lower[a] < head_lower[b];
    endfunction

    function void note_command(logic [1:0] kind, logic [kwm_pkg::PORT_LANE_W-1:0] lane,
                               logic [1:0] cls, logic [63:0] hi, logic [63:0] lo);
        winner_t want;
        bit      found;
        int      best;
        found = 1'b0;
        best  = 0;
        case (kind)
            kwm_pkg::KIND_LOAD: begin
                if (int'(lane) < kwm_pkg::LANES) begin
                    lane_live[lane] = 1'b1;
                    if (cls == kwm_pkg::CLASS_V4) begin
                        head_cls[lane]   = kwm_pkg::CLASS_V4;
                        head_upper[lane] = '0;
                        head_lower[lane] = {32'd0, lo[31:0]};
                    end else if (cls == kwm_pkg::CLASS_V6) begin
                        head_cls[lane]   = kwm_pkg::CLASS_V6;
                        head_upper[lane] = hi;
                        head_lower[lane] = lo;
                    end
                end
            end
            kwm_pkg::KIND_CLOSE: begin
                if (int'(lane) < kwm_pkg::LANES)
                    lane_live[lane] = 1'b0;
            end
            kwm_pkg::KIND_PICK: begin
                for (int i = 0; i < kwm_pkg::LANES; i++) begin
                    if (lane_live[i] && (!found || key_below(i, best))) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                want.lane      = found ? best[kwm_pkg::PORT_LANE_W-1:0] : '0;
                want.none_open = !found;
                expected_winners.push_back(want);
            end
            default: ;
        endcase
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("result %0d: %s", results_seen, what);
    endtask

    task check_result(logic [kwm_pkg::PORT_LANE_W-1:0] lane, logic none_open);
        winner_t want;
        results_seen++;
        if (expected_winners.size() == 0) begin
            report_mismatch("result strobe with no pick waiting");
        end else begin
            want = expected_winners.pop_front();
            if (none_open !== want.none_open)
                report_mismatch($sformatf("none_open %b, expected %b", none_open,
                                          want.none_open));
            if (lane !== want.lane)
                report_mismatch($sformatf("winner_lane %0d, expected %0d", lane, want.lane));
        end
    endtask
endclass

module kway_merge_by_source_address_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kwm_pkg::*;

    // Codes that the block must accept and then ignore.
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam logic [1:0] CLASS_SPARE = 2'd3;

    localparam int RANDOM_BEATS = 1600;
    localparam int SEGMENT_LEN  = 50;
    // The longest correct stretch without any beat or result is a long sender
    // gap plus one pick scan; this limit is far above it.
    localparam int IDLE_LIMIT   = 2000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             i_kind;
    logic [PORT_LANE_W-1:0] i_lane;
    logic [1:0]             i_addr_class;
    logic [63:0]            i_addr_hi;
    logic [63:0]            i_addr_lo;
    logic                   o_valid;
    logic [PORT_LANE_W-1:0] o_winner_lane;
    logic                   o_none_open;

    winner_scoreboard board = new();
    int               idle_cycles = 0;
    bit               gaps_on     = 1'b1;

    kway_merge_by_source_address_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_lane        (i_lane),
        .i_addr_class  (i_addr_class),
        .i_addr_hi     (i_addr_hi),
        .i_addr_lo     (i_addr_lo),
        .o_valid       (o_valid),
        .o_winner_lane (o_winner_lane),
        .o_none_open   (o_none_open)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Monitor and watchdog. All inputs are driven with nonblocking assignments
    // at the rising edge, so the values read here are the ones the block saw at
    // this edge. A command beat and its result never share an edge, since a
    // pick raises its strobe only in the report state, after its scan and drain.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                board.note_command(i_kind, i_lane, i_addr_class, i_addr_hi, i_addr_lo);
            if (o_valid)
                board.check_result(o_winner_lane, o_none_open);
        end
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Mostly back-to-back beats, some short pauses and a few long ones. Whole
    // segments run with no pauses at all.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Address halves lean toward zero, all ones and a few small values so that equal keys and
    // near ties turn up often, while full random words still cover every bit.
    function automatic logic [63:0] rand_half();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Presents one command beat and returns at the edge that accepts it. Start
    // stays high on return, so a following beat with no pause only changes the
    // fields at that same edge and start gets a single assignment.
    task automatic drive_beat(input logic [1:0] kind, input logic [PORT_LANE_W-1:0] lane,
                              input logic [1:0] cls, input logic [63:0] hi,
                              input logic [63:0] lo);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= kind;
        i_lane       <= lane;
        i_addr_class <= cls;
        i_addr_hi    <= hi;
        i_addr_lo    <= lo;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic drive_pick();
        drive_beat(KIND_PICK, PORT_LANE_W'($urandom), 2'($urandom), rand_half(), rand_half());
    endtask

    initial begin
        int         done_beats;
        int         r;
        int         close_pct;
        int         load_pct;
        logic [1:0] cls;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_kind       <= KIND_LOAD;
        i_lane       <= '0;
        i_addr_class <= CLASS_NONE;
        i_addr_hi    <= '0;
        i_addr_lo    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A pick with every lane closed returns the done flag.
        drive_pick();
        // A non-IP load opens lane 0 with the all-zero key left by reset.
        drive_beat(KIND_LOAD, 4'd0, CLASS_NONE, '1, '1);
        // IPv4 load drops the upper half and the top of the lower half.
        drive_beat(KIND_LOAD, 4'd15, CLASS_V4, '1, '1);
        drive_beat(KIND_LOAD, 4'd7, CLASS_V6, '1, '1);
        drive_beat(KIND_LOAD, 4'd3, CLASS_V6, '0, '0);
        // Class none sorts below every IP key.
        drive_pick();
        drive_beat(KIND_CLOSE, 4'd0, CLASS_V6, '1, '1);
        // Closing an already closed lane changes nothing.
        drive_beat(KIND_CLOSE, 4'd0, CLASS_V4, '0, '0);
        // IPv4 sorts below IPv6 even with a larger address.
        drive_pick();
        // Same IPv4 address on lane 5: the tie goes to the lower lane.
        drive_beat(KIND_LOAD, 4'd5, CLASS_V4, 64'h1234, 64'hABCD_0000_FFFF_FFFF);
        // Reserved class code acts as a non-IP load and keeps the old key.
        drive_beat(KIND_LOAD, 4'd15, CLASS_SPARE, '0, '0);
        drive_pick();
        drive_beat(KIND_CLOSE, 4'd5, CLASS_NONE, '0, '0);
        drive_beat(KIND_CLOSE, 4'd15, CLASS_NONE, '0, '0);
        drive_pick();
        // The upper half decides before the lower half.
        drive_beat(KIND_LOAD, 4'd9, CLASS_V6, '0, 64'd1);
        drive_beat(KIND_LOAD, 4'd3, CLASS_V6, 64'd1, '0);
        drive_pick();
        // Reserved kind code is taken and gives no result.
        drive_beat(KIND_SPARE, 4'd4, CLASS_V6, '1, '1);
        drive_beat(KIND_CLOSE, 4'd3, CLASS_NONE, '0, '0);
        drive_beat(KIND_CLOSE, 4'd7, CLASS_NONE, '0, '0);
        drive_beat(KIND_CLOSE, 4'd9, CLASS_NONE, '0, '0);
        drive_pick();

        // Random part, in segments. Normal segments keep most lanes open the way
        // a running merge does; draining segments close lanes faster, and some
        // segments start by closing every lane so the done flag shows up again.
        done_beats = 0;
        close_pct  = 10;
        load_pct   = 45;
        while (done_beats < RANDOM_BEATS) begin
            if (done_beats % SEGMENT_LEN == 0) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 2) == 0) begin
                    load_pct  = 10;
                    close_pct = 50;
                end else begin
                    load_pct  = 45;
                    close_pct = 10;
                end
                if ($urandom_range(0, 3) == 0) begin
                    for (int i = 0; i < LANES; i++)
                        drive_beat(KIND_CLOSE, PORT_LANE_W'(i), 2'($urandom), rand_half(),
                                   rand_half());
                    drive_pick();
                    done_beats += LANES + 1;
                end
            end
            r = $urandom_range(0, 99);
            if (r < load_pct) begin
                r = $urandom_range(0, 99);
                cls = (r < 35) ? CLASS_V4 : (r < 80) ? CLASS_V6 :
                      (r < 90) ? CLASS_NONE : CLASS_SPARE;
                drive_beat(KIND_LOAD, PORT_LANE_W'($urandom), cls, rand_half(), rand_half());
                done_beats++;
            end else if (r < load_pct + close_pct) begin
                drive_beat(KIND_CLOSE, PORT_LANE_W'($urandom), 2'($urandom), rand_half(),
                           rand_half());
                done_beats++;
            end else if (r < 97) begin
                drive_pick();
                done_beats++;
            end else begin
                drive_beat(KIND_SPARE, PORT_LANE_W'($urandom), 2'($urandom), rand_half(),
                           rand_half());
            end
        end
        start <= 1'b0;

        // Wait for the last winners, then a little longer to catch a stray strobe.
        while (board.expected_winners.size() != 0)
            @(posedge i_clk);
        repeat (LANES + 8) @(posedge i_clk);

        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_dp.sv
hw/rtl/kwm_ctrl.sv
hw/rtl/kway_merge_by_source_address_top.sv
bench/kway_merge_by_source_address_top_tb.sv
